// File: rtl/ngh_pkg.sv
// Shared types and constants for the noise gate with hold and hysteresis.
// Used by cfg, env, gate, merge and the top in rtl; no dependencies.
`default_nettype none

package ngh_pkg;

  // Unity gain and full-scale envelope, Q1.23
  localparam logic [23:0] ONE_Q23 = 24'h800000;

  // Gate modes
  localparam logic [1:0] MODE_CLOSED  = 2'd0;
  localparam logic [1:0] MODE_ATTACK  = 2'd1;
  localparam logic [1:0] MODE_HOLD    = 2'd2;
  localparam logic [1:0] MODE_RELEASE = 2'd3;

  // Register map indexes (byte address = 4 * index)
  localparam int unsigned CFG_ADDR_BITS = 5;
  localparam logic [2:0] REG_ENV_ATTACK  = 3'd0;
  localparam logic [2:0] REG_ENV_RELEASE = 3'd1;
  localparam logic [2:0] REG_OPEN_LEVEL  = 3'd2;
  localparam logic [2:0] REG_CLOSE_LEVEL = 3'd3;
  localparam logic [2:0] REG_FLOOR_GAIN  = 3'd4;
  localparam logic [2:0] REG_RISE_STEP   = 3'd5;
  localparam logic [2:0] REG_FALL_STEP   = 3'd6;
  localparam logic [2:0] REG_HOLD_LENGTH = 3'd7;

  // Register reset values
  localparam logic [23:0] RST_ENV_ATTACK  = 24'd16431303;
  localparam logic [23:0] RST_ENV_RELEASE = 24'd16775469;
  localparam logic [23:0] RST_OPEN_LEVEL  = 24'd83886;
  localparam logic [23:0] RST_CLOSE_LEVEL = 24'd42043;
  localparam logic [23:0] RST_FLOOR_GAIN  = 24'd265;
  localparam logic [23:0] RST_RISE_STEP   = 24'd174763;
  localparam logic [23:0] RST_FALL_STEP   = 24'd874;
  localparam logic [15:0] RST_HOLD_LENGTH = 16'd4800;

  typedef struct packed {
    logic [23:0] env_attack_coeff;
    logic [23:0] env_release_coeff;
    logic [23:0] open_level;
    logic [23:0] close_level;
    logic [23:0] floor_gain;
    logic [23:0] rise_step;
    logic [23:0] fall_step;
    logic [15:0] hold_length;
  } cfg_t;

  // Gate state as seen by the lanes and the output stage
  typedef struct packed {
    logic [23:0] gain;
    logic [1:0]  mode;
  } gate_res_t;

endpackage

`default_nettype wire

// File: rtl/ngh_if.sv
// Valid/ready channel interfaces for frames in and gated frames out.
// Channel widths follow CHANNELS and SAMPLE_BITS; no package use.
`default_nettype none

interface ngh_in_if #(
  parameter int CHANNELS    = 2,
  parameter int SAMPLE_BITS = 24
) ();
  logic                            valid;
  logic                            ready;
  logic signed [23:0]              detect_sample;
  logic [CHANNELS*SAMPLE_BITS-1:0] chan_sample;

  modport source (output valid, output detect_sample, output chan_sample, input ready);
  modport sink   (input valid, input detect_sample, input chan_sample, output ready);
endinterface

interface ngh_out_if #(
  parameter int CHANNELS    = 2,
  parameter int SAMPLE_BITS = 24
) ();
  logic                            valid;
  logic                            ready;
  logic [CHANNELS*SAMPLE_BITS-1:0] chan_out;
  logic [23:0]                     applied_gain;
  logic [1:0]                      gate_mode;

  modport source (output valid, output chan_out, output applied_gain, output gate_mode,
                  input ready);
  modport sink   (input valid, input chan_out, input applied_gain, input gate_mode,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/ngh_cfg.sv
// APB register file for the gate: coefficients, levels, steps and hold time.
// Depends on ngh_pkg for the register map, reset values and cfg_t.
`default_nettype none

module ngh_cfg (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [ngh_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  wire logic [31:0]                         pwdata,
  output logic      [31:0]                         prdata,
  output logic                                     pready,
  output ngh_pkg::cfg_t                            cfg
);

  ngh_pkg::cfg_t cfg_r;
  ngh_pkg::cfg_t cfg_nxt;
  logic [2:0]    idx;
  logic          wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      unique case (idx)
        ngh_pkg::REG_ENV_ATTACK:  cfg_nxt.env_attack_coeff  = pwdata[23:0];
        ngh_pkg::REG_ENV_RELEASE: cfg_nxt.env_release_coeff = pwdata[23:0];
        ngh_pkg::REG_OPEN_LEVEL:  cfg_nxt.open_level        = pwdata[23:0];
        ngh_pkg::REG_CLOSE_LEVEL: cfg_nxt.close_level       = pwdata[23:0];
        ngh_pkg::REG_FLOOR_GAIN:  cfg_nxt.floor_gain        = pwdata[23:0];
        ngh_pkg::REG_RISE_STEP:   cfg_nxt.rise_step         = pwdata[23:0];
        ngh_pkg::REG_FALL_STEP:   cfg_nxt.fall_step         = pwdata[23:0];
        ngh_pkg::REG_HOLD_LENGTH: cfg_nxt.hold_length       = pwdata[15:0];
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ngh_pkg::REG_ENV_ATTACK:  prdata = {8'd0, cfg_r.env_attack_coeff};
      ngh_pkg::REG_ENV_RELEASE: prdata = {8'd0, cfg_r.env_release_coeff};
      ngh_pkg::REG_OPEN_LEVEL:  prdata = {8'd0, cfg_r.open_level};
      ngh_pkg::REG_CLOSE_LEVEL: prdata = {8'd0, cfg_r.close_level};
      ngh_pkg::REG_FLOOR_GAIN:  prdata = {8'd0, cfg_r.floor_gain};
      ngh_pkg::REG_RISE_STEP:   prdata = {8'd0, cfg_r.rise_step};
      ngh_pkg::REG_FALL_STEP:   prdata = {8'd0, cfg_r.fall_step};
      ngh_pkg::REG_HOLD_LENGTH: prdata = {16'd0, cfg_r.hold_length};
      default:                  prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.env_attack_coeff  <= ngh_pkg::RST_ENV_ATTACK;
      cfg_r.env_release_coeff <= ngh_pkg::RST_ENV_RELEASE;
      cfg_r.open_level        <= ngh_pkg::RST_OPEN_LEVEL;
      cfg_r.close_level       <= ngh_pkg::RST_CLOSE_LEVEL;
      cfg_r.floor_gain        <= ngh_pkg::RST_FLOOR_GAIN;
      cfg_r.rise_step         <= ngh_pkg::RST_RISE_STEP;
      cfg_r.fall_step         <= ngh_pkg::RST_FALL_STEP;
      cfg_r.hold_length       <= ngh_pkg::RST_HOLD_LENGTH;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/ngh_env.sv
// Envelope follower: rectify the detection sample and apply the one-pole
// attack/release smoother. Depends on ngh_pkg for cfg_t and ONE_Q23.
`default_nettype none

module ngh_env (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               accept,
  input  wire logic signed [23:0] detect_sample,
  input  wire ngh_pkg::cfg_t      cfg,
  output logic             [23:0] env_level
);

  logic        [23:0] env_r;
  logic        [23:0] env_nxt;
  logic        [24:0] neg_x;
  logic        [23:0] abs_x;
  logic        [23:0] coeff;
  logic        [24:0] k;
  logic signed [24:0] diff;
  logic signed [50:0] prod;

  // |-1.0| = 2^23 still fits the 24-bit magnitude
  assign neg_x = 25'd0 - {detect_sample[23], detect_sample};
  assign abs_x = detect_sample[23] ? neg_x[23:0] : detect_sample;

  assign coeff = (abs_x > env_r) ? cfg.env_attack_coeff : cfg.env_release_coeff;
  assign k     = 25'h1000000 - {1'b0, coeff};
  assign diff  = $signed({1'b0, abs_x}) - $signed({1'b0, env_r});
  assign prod  = $signed({1'b0, k}) * diff;

  // Arithmetic shift floors the step, so the envelope never overshoots |x|
  assign env_nxt = env_r + prod[47:24];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      env_r <= 24'd0;
    end else if (accept) begin
      env_r <= env_nxt;
    end
  end

  assign env_level = env_r;

  a_env_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    env_r <= ngh_pkg::ONE_Q23)
    else $error("envelope above full scale");

endmodule

`default_nettype wire

// File: rtl/ngh_gate.sv
// Four-mode gate (closed, attack, hold, release) with gain ramp and hold count.
// Depends on ngh_pkg for mode codes, cfg_t and gate_res_t.
`default_nettype none

module ngh_gate (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step,
  input  wire logic   [23:0] env_level,
  input  wire ngh_pkg::cfg_t cfg,
  output ngh_pkg::gate_res_t res
);

  logic        [1:0]  mode_r;
  logic        [1:0]  mode_nxt;
  logic        [23:0] gain_r;
  logic        [23:0] gain_nxt;
  logic        [15:0] hold_r;
  logic        [15:0] hold_nxt;
  logic        [24:0] gain_up;
  logic signed [25:0] gain_dn;
  logic        [23:0] floor_sat;
  logic               env_open;
  logic               env_low;
  logic               at_floor;

  assign gain_up   = {1'b0, gain_r} + {1'b0, cfg.rise_step};
  assign gain_dn   = $signed({2'b00, gain_r}) - $signed({2'b00, cfg.fall_step});
  assign at_floor  = gain_dn <= $signed({2'b00, cfg.floor_gain});
  assign floor_sat = (cfg.floor_gain > ngh_pkg::ONE_Q23) ? ngh_pkg::ONE_Q23 : cfg.floor_gain;
  assign env_open  = env_level >= cfg.open_level;
  assign env_low   = env_level < cfg.close_level;

  always_comb begin
    mode_nxt = mode_r;
    gain_nxt = gain_r;
    hold_nxt = hold_r;
    unique case (mode_r)
      ngh_pkg::MODE_CLOSED: begin
        if (env_open) mode_nxt = ngh_pkg::MODE_ATTACK;
      end
      ngh_pkg::MODE_ATTACK: begin
        if (gain_up >= {1'b0, ngh_pkg::ONE_Q23}) begin
          gain_nxt = ngh_pkg::ONE_Q23;
          mode_nxt = ngh_pkg::MODE_HOLD;
          hold_nxt = cfg.hold_length;
        end else begin
          gain_nxt = gain_up[23:0];
          if (env_low) mode_nxt = ngh_pkg::MODE_RELEASE;
        end
      end
      ngh_pkg::MODE_HOLD: begin
        if (env_low) begin
          if (hold_r != 16'd0) hold_nxt = hold_r - 16'd1;
          else                 mode_nxt = ngh_pkg::MODE_RELEASE;
        end else begin
          hold_nxt = cfg.hold_length;
        end
      end
      ngh_pkg::MODE_RELEASE: begin
        // at floor: land (never above unity) and close; env_open reopens
        if (at_floor) begin
          gain_nxt = floor_sat;
          mode_nxt = ngh_pkg::MODE_CLOSED;
        end else begin
          gain_nxt = gain_dn[23:0];
        end
        if (env_open) mode_nxt = ngh_pkg::MODE_ATTACK;
      end
      default: mode_nxt = mode_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ngh_pkg::MODE_CLOSED;
      gain_r <= 24'd0;
      hold_r <= 16'd0;
    end else if (step) begin
      mode_r <= mode_nxt;
      gain_r <= gain_nxt;
      hold_r <= hold_nxt;
    end
  end

  assign res.gain = gain_r;
  assign res.mode = mode_r;

  a_gain_max: assert property (@(posedge clk) disable iff (!rst_n)
    gain_r <= ngh_pkg::ONE_Q23)
    else $error("gain above unity");

  a_hold_unity: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == ngh_pkg::MODE_HOLD) |-> (gain_r == ngh_pkg::ONE_Q23))
    else $error("hold mode without unity gain");

endmodule

`default_nettype wire

// File: rtl/ngh_lane.sv
// One channel lane: scale a sample by the gate gain, floor to SAMPLE_BITS.
// Standalone; registers its result on the pipeline enable.
`default_nettype none

module ngh_lane #(
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  input  wire logic [23:0]            gain,
  output logic      [SAMPLE_BITS-1:0] y_r
);

  logic signed [SAMPLE_BITS+24:0] prod;

  assign prod = $signed(sample) * $signed({1'b0, gain});

  // drop 23 fraction bits; gain <= 1.0 keeps the result in range
  always_ff @(posedge clk) begin
    if (en) y_r <= prod[SAMPLE_BITS+22:23];
  end

endmodule

`default_nettype wire

// File: rtl/ngh_merge.sv
// Output stage: gathers the lane results with gain and mode into one transfer,
// with a spare entry so the pipeline keeps moving. Depends on ngh_pkg, ngh_out_if.
`default_nettype none

module ngh_merge #(
  parameter int CHANNELS    = 2,
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            push,
  input  wire logic [CHANNELS*SAMPLE_BITS-1:0] lane_y,
  input  wire ngh_pkg::gate_res_t              res,
  output logic                                 space,
  ngh_out_if.source                            out_ch
);

  logic                            out_v_r;
  logic                            spare_v_r;
  logic [CHANNELS*SAMPLE_BITS-1:0] out_y_r;
  logic [CHANNELS*SAMPLE_BITS-1:0] spare_y_r;
  ngh_pkg::gate_res_t              out_res_r;
  ngh_pkg::gate_res_t              spare_res_r;
  logic                            take;

  assign take  = out_v_r && out_ch.ready;
  assign space = !spare_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r   <= 1'b0;
      spare_v_r <= 1'b0;
    end else begin
      if (push) begin
        if (!out_v_r || take) begin
          out_v_r <= 1'b1;
        end else begin
          spare_v_r <= 1'b1;
        end
      end else if (take) begin
        // refill from the spare entry, else go empty
        out_v_r   <= spare_v_r;
        spare_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && (!out_v_r || take)) begin
      out_y_r   <= lane_y;
      out_res_r <= res;
    end else if (take && spare_v_r) begin
      out_y_r   <= spare_y_r;
      out_res_r <= spare_res_r;
    end
    if (push && out_v_r && !take) begin
      spare_y_r   <= lane_y;
      spare_res_r <= res;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.chan_out     = out_y_r;
  assign out_ch.applied_gain = out_res_r.gain;
  assign out_ch.gate_mode    = out_res_r.mode;

  a_spare_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    spare_v_r |-> out_v_r)
    else $error("spare entry held with output empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    spare_v_r |-> !push)
    else $error("result pushed with no room");

endmodule

`default_nettype wire

// File: rtl/noise_gate_hysteresis_hold_core.sv
// Top level of the noise gate with hold and hysteresis: register file,
// envelope, gate, channel lanes and output merge. Depends on ngh_pkg, ngh_if.
`default_nettype none

//  port     | dir | handshake           | payload
//  in_ch    | in  | valid / ready       | detect_sample, chan_sample[CHANNELS]
//  out_ch   | out | valid / ready       | chan_out[CHANNELS], applied_gain, gate_mode
//  APB      | in  | psel/penable/pready | paddr, pwdata, prdata
//
// One frame per cycle sustained while the output stage has room; the envelope
// feedback (one multiply-add per frame) is the loop that sets that figure.
// A frame moves through the envelope, gate, lane and output-stage registers in turn.
// Reset: synchronous, active low; clears the envelope, gain, mode and hold count.
// Stalls: a two-entry output stage takes new results while one waits;
// in_ch.ready drops only when both entries are full or while reset is held.

module noise_gate_hysteresis_hold_core #(
  parameter int CHANNELS    = 2,
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  ngh_in_if.sink                                 in_ch,
  ngh_out_if.source                              out_ch,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [ngh_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  wire logic [31:0]                       pwdata,
  output logic      [31:0]                       prdata,
  output logic                                   pready
);

  ngh_pkg::cfg_t                   cfg;
  ngh_pkg::gate_res_t              gate_res;
  ngh_pkg::gate_res_t              res_s3_r;
  logic                            en;
  logic                            accept;
  logic                            v1_r;
  logic                            v2_r;
  logic                            v3_r;
  logic [23:0]                     env_level;
  logic [CHANNELS*SAMPLE_BITS-1:0] chan_s1_r;
  logic [CHANNELS*SAMPLE_BITS-1:0] chan_s2_r;
  logic [CHANNELS*SAMPLE_BITS-1:0] lane_y;

  assign in_ch.ready = en && rst_n;
  assign accept      = in_ch.valid && en && rst_n;

  ngh_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ngh_env u_env (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .detect_sample (in_ch.detect_sample),
    .cfg           (cfg),
    .env_level     (env_level)
  );

  ngh_gate u_gate (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (en && v1_r),
    .env_level (env_level),
    .cfg       (cfg),
    .res       (gate_res)
  );

  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
    ngh_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane (
      .clk    (clk),
      .en     (en),
      .sample (chan_s2_r[ch*SAMPLE_BITS +: SAMPLE_BITS]),
      .gain   (gate_res.gain),
      .y_r    (lane_y[ch*SAMPLE_BITS +: SAMPLE_BITS])
    );
  end

  ngh_merge #(.CHANNELS(CHANNELS), .SAMPLE_BITS(SAMPLE_BITS)) u_merge (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (en && v3_r),
    .lane_y (lane_y),
    .res    (res_s3_r),
    .space  (en),
    .out_ch (out_ch)
  );

  // advance the whole pipeline together; hold while the output stage is full
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chan_s1_r <= in_ch.chan_sample;
      chan_s2_r <= chan_s1_r;
      res_s3_r  <= gate_res;
    end
  end

endmodule

`default_nettype wire

// File: sim/testbench.sv
// Self-checking bench for noise_gate_hysteresis_hold_core: a stimulus table and then gated
// bursts with random content, checked against a cycle-free model of envelope, gate and gain.
// Depends on ngh_pkg, ngh_in_if and ngh_out_if from rtl.
`timescale 1ns / 1ps

module testbench;

  localparam longint      UNITY         = longint'(ngh_pkg::ONE_Q23);
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned LONG_HOLD     = 80;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned PHASE_ITEMS   = 116;
  localparam int unsigned DIRECTED_ROWS = 22;
  localparam int unsigned RESET_ROWS    = 5;

  // Register settings applied between phases
  localparam int SET_TUNED      = 0;
  localparam int SET_ZERO       = 1;
  localparam int SET_FULL       = 2;
  localparam int SET_HIGH_FLOOR = 3;
  localparam int SET_STEPPED    = 4;

  typedef struct packed {
    logic        known;
    logic [23:0] det;
    logic [23:0] s0;
    logic [23:0] s1;
    logic [23:0] o0;
    logic [23:0] o1;
    logic [23:0] gain;
    logic [1:0]  mode;
  } frame_row_t;

  typedef struct packed {
    logic [23:0] chan0_out;
    logic [23:0] chan1_out;
    logic [23:0] applied_gain;
    logic [1:0]  gate_mode;
  } gated_frame_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [ngh_pkg::CFG_ADDR_BITS-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ngh_in_if  #(.CHANNELS(2), .SAMPLE_BITS(24)) in_bus ();
  ngh_out_if #(.CHANNELS(2), .SAMPLE_BITS(24)) out_bus ();

  noise_gate_hysteresis_hold_core #(.CHANNELS(2), .SAMPLE_BITS(24)) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the register file and of the gate state
  ngh_pkg::cfg_t cfg_q;
  logic [23:0] env_lvl;
  logic [23:0] gain_lvl;
  logic [1:0]  gate_mode_q;
  logic [15:0] hold_left_q;

  gated_frame_t frames_in_flight[$];
  int          fault_count;
  int unsigned stall_cycles = 0;
  bit          src_idle;
  bit          sink_idle;
  bit          sink_long_hold;

  // Directed rows; the known ones: straight after reset and full-scale detection from a closed gate
  frame_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
    '{1'b1, 24'h000000, 24'h7FFFFF, 24'h800000, 24'h0, 24'h0, 24'h0, ngh_pkg::MODE_CLOSED},
    '{1'b1, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h0, 24'h0, 24'h0, ngh_pkg::MODE_ATTACK},
    '{1'b0, 24'h7FFFFF, 24'h7FFFFF, 24'hFFFFFF, 24'h0, 24'h0, 24'h0, ngh_pkg::MODE_CLOSED},
    '{1'b0, 24'h000000, 24'hFFFFFF, 24'h000001, 24'h0, 24'h0, 24'h0, ngh_pkg::MODE_CLOSED},
    '{1'b0, 24'h003039, 24'h400000, 24'hC00000, 24'h0, 24'h0, 24'h0, ngh_pkg::MODE_CLOSED},
    // stepped setting: envelope follows |x|, open 4000000, close 2000000, hold 2
    '{1'b0, 24'h7FFFFF, 24'h123456, 24'hEDCBA9, 24'h0, 24'h0, 24'h0, ngh_pkg::MODE_CLOSED},
    '{1'b0, 24'h800000, 24'h555555, 24'hAAAAAA, 24'h0, 24'h0, 24'h0, ngh_pkg::MODE_CLOSED},
    '{1'b0, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h0, 24'h0, 24'h0, ngh_pkg::MODE_CLOSED},
    '{1'b0, 24'h000000, 24'h0F0F0F, 24'hF0F0F0, 24'h0, 24'h0, 24'h0, ngh_pkg::MODE_CLOSED},
    '{1'b0, 24'h2DC6C0, 24'h333333, 24'hCCCCCC, 24'h0, 24'h0, 24'h0, ngh_pkg::MODE_CLOSED},
    '{1'b0, 24'h000000, 24'h000001, 24'hFFFFFF, 24'h0, 24'h0, 24'h0, ngh_pkg::MODE_CLOSED},
    '{1'b0, 24'h000000, 24'h7FFFFF, 24'h800000, 24'h0, 24'h0, 24'h0, ngh_pkg::MODE_CLOSED},
    '{1'b0, 24'h000000, 24'h400000, 24'hC00000, 24'h0, 24'h0, 24'h0, ngh_pkg::MODE_CLOSED},
    '{1'b0, 24'h2625A0, 24'h7FFFFF, 24'h800000, 24'h0, 24'h0, 24'h0, ngh_pkg::MODE_CLOSED},
    '{1'b0, 24'hB3B4C0, 24'h7FFFFF, 24'h800000, 24'h0, 24'h0, 24'h0, ngh_pkg::MODE_CLOSED},
    '{1'b0, 24'h000000, 24'h7FFFFF, 24'h800000, 24'h0, 24'h0, 24'h0, ngh_pkg::MODE_CLOSED},
    '{1'b0, 24'h000000, 24'h7FFFFF, 24'h800000, 24'h0, 24'h0, 24'h0, ngh_pkg::MODE_CLOSED},
    '{1'b0, 24'h4C4B40, 24'h7FFFFF, 24'h800000, 24'h0, 24'h0, 24'h0, ngh_pkg::MODE_CLOSED},
    '{1'b0, 24'h000000, 24'h7FFFFF, 24'h800000, 24'h0, 24'h0, 24'h0, ngh_pkg::MODE_CLOSED},
    '{1'b0, 24'h000000, 24'h7FFFFF, 24'h800000, 24'h0, 24'h0, 24'h0, ngh_pkg::MODE_CLOSED},
    '{1'b0, 24'h000000, 24'h7FFFFF, 24'h800000, 24'h0, 24'h0, 24'h0, ngh_pkg::MODE_CLOSED},
    '{1'b0, 24'h000000, 24'h800000, 24'h7FFFFF, 24'h0, 24'h0, 24'h0, ngh_pkg::MODE_CLOSED}
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Advance envelope, gate and gain by one frame and scale both channels
  function automatic gated_frame_t gate_frame(input logic [23:0] det, input logic [23:0] s0,
                                              input logic [23:0] s1);
    longint       mag;
    longint       env;
    longint       k;
    longint       g;
    longint       flr;
    longint       open_l;
    longint       close_l;
    longint       p0;
    longint       p1;
    gated_frame_t r;
    mag = longint'($signed(det));
    if (mag < 0) mag = -mag;
    env = longint'(env_lvl);
    k = 64'sd16777216 - longint'((mag > env) ? cfg_q.env_attack_coeff
                                             : cfg_q.env_release_coeff);
    env = env + ((k * (mag - env)) >>> 24);
    env_lvl = env[23:0];
    g = longint'(gain_lvl);
    flr = longint'(cfg_q.floor_gain);
    open_l = longint'(cfg_q.open_level);
    close_l = longint'(cfg_q.close_level);
    case (gate_mode_q)
      ngh_pkg::MODE_CLOSED: begin
        if (env >= open_l) gate_mode_q = ngh_pkg::MODE_ATTACK;
      end
      ngh_pkg::MODE_ATTACK: begin
        g = g + longint'(cfg_q.rise_step);
        if (g >= UNITY) begin
          g = UNITY;
          gate_mode_q = ngh_pkg::MODE_HOLD;
          hold_left_q = cfg_q.hold_length;
        end else if (env < close_l) begin
          gate_mode_q = ngh_pkg::MODE_RELEASE;
        end
      end
      ngh_pkg::MODE_HOLD: begin
        if (env < close_l) begin
          if (hold_left_q != 16'd0) hold_left_q = hold_left_q - 16'd1;
          else gate_mode_q = ngh_pkg::MODE_RELEASE;
        end else begin
          hold_left_q = cfg_q.hold_length;
        end
      end
      default: begin
        g = g - longint'(cfg_q.fall_step);
        // landing on a floor above unity clamps to unity
        if (g <= flr) begin
          g = (flr > UNITY) ? UNITY : flr;
          gate_mode_q = ngh_pkg::MODE_CLOSED;
        end
        if (env >= open_l) gate_mode_q = ngh_pkg::MODE_ATTACK;
      end
    endcase
    if (g < 0) g = 0;
    if (g > UNITY) g = UNITY;
    gain_lvl = g[23:0];
    p0 = (longint'($signed(s0)) * g) >>> 23;
    p1 = (longint'($signed(s1)) * g) >>> 23;
    r.chan0_out = p0[23:0];
    r.chan1_out = p1[23:0];
    r.applied_gain = gain_lvl;
    r.gate_mode = gate_mode_q;
    return r;
  endfunction

  function automatic ngh_pkg::cfg_t pick_setting(input int kind);
    ngh_pkg::cfg_t c;
    c.env_attack_coeff = 24'($urandom_range(0, 24'hE00000));
    c.env_release_coeff = 24'($urandom_range(0, 24'hF00000));
    c.open_level = 24'($urandom_range(24'h080000, 24'h600000));
    c.close_level = 24'($urandom_range(0, c.open_level));
    // now and then invert the hysteresis
    if ($urandom_range(0, 3) == 0) c.close_level = 24'($urandom_range(0, ngh_pkg::ONE_Q23));
    c.floor_gain = 24'($urandom_range(0, 24'h200000));
    c.rise_step = 24'($urandom_range(24'h008000, 24'h400000));
    c.fall_step = 24'($urandom_range(24'h008000, 24'h400000));
    c.hold_length = 16'($urandom_range(0, 24));
    case (kind)
      SET_ZERO:       c = '0;
      SET_FULL:       c = '{24'hFFFFFF, 24'hFFFFFF, ngh_pkg::ONE_Q23, ngh_pkg::ONE_Q23,
                            ngh_pkg::ONE_Q23, ngh_pkg::ONE_Q23, ngh_pkg::ONE_Q23, 16'hFFFF};
      SET_HIGH_FLOOR: c.floor_gain = 24'($urandom_range(24'h800001, 24'hFFFFFF));
      SET_STEPPED:    c = '{24'd0, 24'd0, 24'd4000000, 24'd2000000, 24'd1000, 24'd3000000,
                            24'd3000000, 16'd2};
      default: ;
    endcase
    return c;
  endfunction

  function automatic logic [23:0] sample_word();
    logic [31:0] r;
    r = $urandom;
    if (r[31:29] != 3'd0) return r[23:0];
    case (r[1:0])
      2'd0:    return 24'h7FFFFF;
      2'd1:    return 24'h800000;
      2'd2:    return 24'h000000;
      default: return 24'hFFFFFF;
    endcase
  endfunction

  // Junk above the register width must be dropped by the block
  task automatic write_reg(input logic [2:0] idx, input logic [23:0] value);
    logic [31:0] junk;
    junk = $urandom;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= (idx == ngh_pkg::REG_HOLD_LENGTH) ? {junk[15:0], value[15:0]}
                                                : {junk[7:0], value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      ngh_pkg::REG_ENV_ATTACK:  cfg_q.env_attack_coeff = value;
      ngh_pkg::REG_ENV_RELEASE: cfg_q.env_release_coeff = value;
      ngh_pkg::REG_OPEN_LEVEL:  cfg_q.open_level = value;
      ngh_pkg::REG_CLOSE_LEVEL: cfg_q.close_level = value;
      ngh_pkg::REG_FLOOR_GAIN:  cfg_q.floor_gain = value;
      ngh_pkg::REG_RISE_STEP:   cfg_q.rise_step = value;
      ngh_pkg::REG_FALL_STEP:   cfg_q.fall_step = value;
      default:                  cfg_q.hold_length = value[15:0];
    endcase
  endtask

  task automatic set_config(input ngh_pkg::cfg_t c);
    write_reg(ngh_pkg::REG_ENV_ATTACK, c.env_attack_coeff);
    write_reg(ngh_pkg::REG_ENV_RELEASE, c.env_release_coeff);
    write_reg(ngh_pkg::REG_OPEN_LEVEL, c.open_level);
    write_reg(ngh_pkg::REG_CLOSE_LEVEL, c.close_level);
    write_reg(ngh_pkg::REG_FLOOR_GAIN, c.floor_gain);
    write_reg(ngh_pkg::REG_RISE_STEP, c.rise_step);
    write_reg(ngh_pkg::REG_FALL_STEP, c.fall_step);
    write_reg(ngh_pkg::REG_HOLD_LENGTH, {8'd0, c.hold_length});
  endtask

  task automatic send_frame(input frame_row_t row);
    gated_frame_t due;
    int unsigned  gap;
    gap = src_idle ? $urandom_range(0, 11) : 0;
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.detect_sample <= row.det;
    in_bus.chan_sample <= {row.s1, row.s0};
    do @(posedge clk); while (!in_bus.ready);
    due = gate_frame(row.det, row.s0, row.s1);
    if (row.known) due = '{row.o0, row.o1, row.gain, row.mode};
    frames_in_flight.push_back(due);
  endtask

  // Frames whose detection magnitude lies between lo and hi, random sign
  task automatic emit_run(input int unsigned count, input int unsigned lo,
                          input int unsigned hi);
    frame_row_t  row;
    logic [23:0] m24;
    repeat (count) begin
      m24 = 24'($urandom_range(lo, hi));
      row = '0;
      row.det = ($urandom_range(0, 1) == 1) ? -m24 : m24;
      row.s0 = sample_word();
      row.s1 = sample_word();
      send_frame(row);
    end
  endtask

  task automatic settle_block();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (frames_in_flight.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int          i;
    int          ph;
    int          kind;
    int unsigned sent;
    int unsigned rem;
    int unsigned n1;
    int unsigned n2;
    int unsigned pick;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_bus.valid = 1'b0;
    in_bus.detect_sample = '0;
    in_bus.chan_sample = '0;
    fault_count = 0;
    src_idle = 1'b1;
    sink_idle = 1'b1;
    sink_long_hold = 1'b0;
    cfg_q = '{ngh_pkg::RST_ENV_ATTACK, ngh_pkg::RST_ENV_RELEASE, ngh_pkg::RST_OPEN_LEVEL,
              ngh_pkg::RST_CLOSE_LEVEL, ngh_pkg::RST_FLOOR_GAIN, ngh_pkg::RST_RISE_STEP,
              ngh_pkg::RST_FALL_STEP, ngh_pkg::RST_HOLD_LENGTH};
    env_lvl = '0;
    gain_lvl = '0;
    gate_mode_q = ngh_pkg::MODE_CLOSED;
    hold_left_q = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < DIRECTED_ROWS; i++) begin
      if (i == RESET_ROWS) begin
        settle_block();
        set_config(pick_setting(SET_STEPPED));
      end
      send_frame(directed_rows[i]);
    end

    for (ph = 0; ph < PHASES; ph++) begin
      settle_block();
      kind = (ph == 1) ? SET_ZERO : (ph == 3) ? SET_FULL :
             (ph == 4) ? SET_HIGH_FLOOR : SET_TUNED;
      set_config(pick_setting(kind));
      sent = 0;
      if (ph == 0) begin
        // hold the receiver off while frames keep coming so the input stalls
        src_idle = 1'b0;
        sink_long_hold = 1'b1;
        emit_run(40, cfg_q.open_level, ngh_pkg::ONE_Q23);
        sent = 40;
      end
      while (sent < PHASE_ITEMS) begin
        src_idle = ($urandom_range(0, 3) != 0);
        sink_idle = ($urandom_range(0, 3) != 0);
        pick = $urandom_range(0, 9);
        n1 = $urandom_range(1, 30);
        n2 = $urandom_range(1, 40);
        // keep each phase to its share of frames
        rem = PHASE_ITEMS - sent;
        if (n1 > rem) n1 = rem;
        if (n2 > rem) n2 = rem;
        if (pick < 7) begin
          if (n1 + n2 > rem) n2 = rem - n1;
          emit_run(n1, cfg_q.open_level, ngh_pkg::ONE_Q23);
          emit_run(n2, 0, cfg_q.close_level);
          sent += n1 + n2;
        end else if (pick < 9) begin
          emit_run(n2, 0, cfg_q.close_level);
          sent += n2;
        end else begin
          emit_run(n1 / 3 + 1, 0, ngh_pkg::ONE_Q23);
          sent += n1 / 3 + 1;
        end
      end
    end

    settle_block();
    if (fault_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : sink
    int unsigned gap;
    out_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = sink_idle ? $urandom_range(0, 11) : 0;
      if (sink_long_hold) begin
        gap = LONG_HOLD;
        sink_long_hold = 1'b0;
      end
      if (gap != 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!(out_bus.valid && out_bus.ready));
    end
  end

  always @(posedge clk) begin : check_out
    gated_frame_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (frames_in_flight.size() == 0) begin
        $error("gated frame with none pending: gain %0d mode %0d",
               out_bus.applied_gain, out_bus.gate_mode);
        fault_count++;
      end else begin
        want = frames_in_flight.pop_front();
        if (out_bus.chan_out[23:0] !== want.chan0_out) begin
          $error("chan0_out: expected %0d, got %0d", $signed(want.chan0_out),
                 $signed(out_bus.chan_out[23:0]));
          fault_count++;
        end
        if (out_bus.chan_out[47:24] !== want.chan1_out) begin
          $error("chan1_out: expected %0d, got %0d", $signed(want.chan1_out),
                 $signed(out_bus.chan_out[47:24]));
          fault_count++;
        end
        if (out_bus.applied_gain !== want.applied_gain) begin
          $error("applied_gain: expected %0d, got %0d", want.applied_gain,
                 out_bus.applied_gain);
          fault_count++;
        end
        if (out_bus.gate_mode !== want.gate_mode) begin
          $error("gate_mode: expected %0d, got %0d", want.gate_mode, out_bus.gate_mode);
          fault_count++;
        end
      end
    end
  end

  // Drop the run if nothing moves for too long
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) || psel) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule

// File: filelist.f
rtl/ngh_pkg.sv
rtl/ngh_if.sv
rtl/ngh_cfg.sv
rtl/ngh_env.sv
rtl/ngh_gate.sv
rtl/ngh_lane.sv
rtl/ngh_merge.sv
rtl/noise_gate_hysteresis_hold_core.sv
sim/testbench.sv
